### hw/rtl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds the transfer structs, command and status codes, and the controller/datapath interface.
// No dependencies.
package gha_pkg;

    localparam int DEFAULT_SLOT_CAPACITY = 256;
    localparam int CFG_W                 = 9;
    localparam int INDEX_W               = 24;
    localparam int GEN_W                 = 8;
    localparam int STATUS_W              = 2;

    localparam logic [CFG_W-1:0]    MAX_SLOTS_RESET = 9'd256;
    localparam logic [INDEX_W-1:0]  INVALID_INDEX   = 24'hFFFFFF;
    localparam logic [GEN_W-1:0]    INVALID_GEN     = 8'hFF;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] handle_index;
        logic [GEN_W-1:0]   handle_generation;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0]  result_index;
        logic [GEN_W-1:0]    result_generation;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // How the latched request proceeds after decode
    typedef enum logic [1:0] {
        PATH_DIRECT = 2'd0,
        PATH_QUEUE  = 2'd1,
        PATH_GEN    = 2'd2
    } t_path;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic finish_direct;
        logic q_rd;
        logic g_rd_req;
        logic g_rd_q;
        logic finish_gen;
    } t_ctl;

    typedef struct packed {
        logic  clear_last;
        t_path path;
    } t_sts;

endpackage

### hw/rtl/gha_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/gha_ctrl.sv
// Controller state machine for the generational handle allocator.
// Sequences clear pass, decode and memory waits; depends on gha_pkg.
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gha_pkg::t_sts i_sts,
    output gha_pkg::t_ctl o_ctl,
    output logic          o_busy
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECODE = 5'b00100,
        S_QWAIT  = 5'b01000,
        S_GWAIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.path)
                    gha_pkg::PATH_QUEUE: begin
                        o_ctl.q_rd = 1'b1;
                        n_state    = S_QWAIT;
                    end
                    gha_pkg::PATH_GEN: begin
                        o_ctl.g_rd_req = 1'b1;
                        n_state        = S_GWAIT;
                    end
                    default: begin
                        o_ctl.finish_direct = 1'b1;
                        n_state             = S_IDLE;
                    end
                endcase
            end
            S_QWAIT: begin
                // queue data is out; fetch the generation of that slot
                o_ctl.g_rd_q = 1'b1;
                n_state      = S_GWAIT;
            end
            S_GWAIT: begin
                o_ctl.finish_gen = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hw/rtl/gha_datapath.sv
// Datapath for the generational handle allocator: generation store, free FIFO, counters.
// Depends on gha_pkg and gha_ram.
module gha_datapath #(
    parameter int SLOT_CAPACITY = gha_pkg::DEFAULT_SLOT_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gha_pkg::t_ctl              i_ctl,
    output gha_pkg::t_sts              o_sts,
    input  gha_pkg::t_req              i_req,
    input  logic                       i_cfg_we,
    input  logic [gha_pkg::CFG_W-1:0]  i_cfg_wdata,
    output gha_pkg::t_rsp              o_rsp,
    output logic                       o_rsp_valid
);

    localparam int IW = $clog2(SLOT_CAPACITY);
    localparam int CW = $clog2(SLOT_CAPACITY + 1);
    localparam int LW = (CW > gha_pkg::CFG_W) ? CW : gha_pkg::CFG_W;
    localparam int GW = gha_pkg::GEN_W;
    localparam int XW = gha_pkg::INDEX_W;

    logic [gha_pkg::CFG_W-1:0] r_max_slots;
    gha_pkg::t_req             r_req;
    logic [IW-1:0]             r_head;
    logic [IW-1:0]             n_head;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CW-1:0]             r_issued;
    logic [CW-1:0]             n_issued;
    logic [IW-1:0]             r_clr_addr;
    logic [IW-1:0]             r_slot;
    gha_pkg::t_rsp             r_rsp;
    gha_pkg::t_rsp             n_rsp;
    logic                      r_rsp_valid;
    logic                      n_rsp_valid;

    logic [LW-1:0]             max_ext;
    logic [LW-1:0]             limit;
    logic                      in_range;
    logic [CW:0]               tail_sum;
    logic [IW-1:0]             tail;
    logic [IW-1:0]             idx_lo;
    gha_pkg::t_path            path;
    gha_pkg::t_rsp             d_rsp;
    logic                      d_fresh;

    logic                      g_we;
    logic [IW-1:0]             g_waddr;
    logic [GW-1:0]             g_wdata;
    logic                      g_re;
    logic [IW-1:0]             g_raddr;
    logic [GW-1:0]             g_rdata;
    logic                      q_we;
    logic [IW-1:0]             q_rdata;

    // Effective slot limit: min(max_slots, capacity)
    assign max_ext  = LW'(r_max_slots);
    assign limit    = (max_ext > LW'(SLOT_CAPACITY)) ? LW'(SLOT_CAPACITY) : max_ext;
    assign in_range = (r_req.handle_index < XW'(limit));
    assign idx_lo   = r_req.handle_index[IW-1:0];

    // Tail of the circular queue; head + count stays below twice the capacity
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail     = (tail_sum >= (CW+1)'(SLOT_CAPACITY))
                    ? IW'(tail_sum - (CW+1)'(SLOT_CAPACITY))
                    : IW'(tail_sum);

    // Decode of the latched request
    always_comb begin
        path    = gha_pkg::PATH_DIRECT;
        d_fresh = 1'b0;
        d_rsp   = '{result_index: '0, result_generation: '0, status: gha_pkg::ST_FULL};
        unique case (r_req.command)
            gha_pkg::CMD_CREATE: begin
                if (r_count != '0) begin
                    path = gha_pkg::PATH_QUEUE;
                end else if (LW'(r_issued) < limit) begin
                    d_fresh = 1'b1;
                    d_rsp   = '{result_index: XW'(r_issued), result_generation: '0,
                                status: gha_pkg::ST_OK};
                end else begin
                    d_rsp = '{result_index: gha_pkg::INVALID_INDEX,
                              result_generation: gha_pkg::INVALID_GEN,
                              status: gha_pkg::ST_FULL};
                end
            end
            gha_pkg::CMD_DESTROY: begin
                if (!in_range) begin
                    d_rsp.status = gha_pkg::ST_MISS;
                end else if (r_count == CW'(SLOT_CAPACITY)) begin
                    d_rsp.status = gha_pkg::ST_FULL;
                end else begin
                    path = gha_pkg::PATH_GEN;
                end
            end
            gha_pkg::CMD_CHECK: begin
                if (!in_range) begin
                    d_rsp.status = gha_pkg::ST_MISS;
                end else begin
                    path = gha_pkg::PATH_GEN;
                end
            end
            default: begin
                d_rsp.status = gha_pkg::ST_FULL;
            end
        endcase
    end

    assign o_sts.path       = path;
    assign o_sts.clear_last = (r_clr_addr == IW'(SLOT_CAPACITY - 1));

    assign g_re    = i_ctl.g_rd_req | i_ctl.g_rd_q;
    assign g_raddr = i_ctl.g_rd_q ? q_rdata : idx_lo;

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_issued    = r_issued;
        n_rsp       = r_rsp;
        n_rsp_valid = 1'b0;
        g_we        = 1'b0;
        g_waddr     = idx_lo;
        g_wdata     = '0;
        q_we        = 1'b0;

        if (i_ctl.clear_step) begin
            g_we    = 1'b1;
            g_waddr = r_clr_addr;
        end

        if (i_ctl.finish_direct) begin
            n_rsp       = d_rsp;
            n_rsp_valid = 1'b1;
            if (d_fresh) begin
                // fresh slot starts at generation zero
                g_we     = 1'b1;
                g_waddr  = r_issued[IW-1:0];
                n_issued = r_issued + CW'(1);
            end
        end

        if (i_ctl.finish_gen) begin
            n_rsp_valid = 1'b1;
            n_rsp       = '{result_index: '0, result_generation: '0, status: gha_pkg::ST_OK};
            case (r_req.command)
                gha_pkg::CMD_CREATE: begin
                    n_rsp.result_index      = XW'(r_slot);
                    n_rsp.result_generation = g_rdata;
                    n_head  = (r_head == IW'(SLOT_CAPACITY - 1)) ? '0 : r_head + IW'(1);
                    n_count = r_count - CW'(1);
                end
                gha_pkg::CMD_DESTROY: begin
                    // bump generation, append index to the free queue
                    g_we    = 1'b1;
                    g_waddr = idx_lo;
                    g_wdata = g_rdata + GW'(1);
                    q_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
                gha_pkg::CMD_CHECK: begin
                    n_rsp.status = (g_rdata == r_req.handle_generation)
                                 ? gha_pkg::ST_OK : gha_pkg::ST_MISS;
                end
                default: begin
                    n_rsp.status = gha_pkg::ST_FULL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_slots <= gha_pkg::MAX_SLOTS_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_issued    <= '0;
            r_clr_addr  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_slots <= i_cfg_wdata;
            end
            if (i_ctl.clear_step) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            r_head      <= n_head;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_req <= i_req;
        end
        if (i_ctl.g_rd_q) begin
            r_slot <= q_rdata;
        end
        r_rsp <= n_rsp;
    end

    gha_ram #(
        .WIDTH (GW),
        .DEPTH (SLOT_CAPACITY)
    ) u_gen_store (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    gha_ram #(
        .WIDTH (IW),
        .DEPTH (SLOT_CAPACITY)
    ) u_free_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (tail),
        .i_wdata (idx_lo),
        .i_re    (i_ctl.q_rd),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

### hw/rtl/generational_handle_allocator.sv
// Generational handle allocator, top level. Depends on gha_pkg, gha_ctrl, gha_datapath.
// Commands settled at decode (fresh create, refusals, out of range) answer from decode;
// destroy/check read the generation store first; create from the free queue reads the
// queue, then the generation store. Busy, which holds off new commands, covers decode plus
// the registered reads of both RAMs. The receiver cannot stall; each result shows for 1 cycle.
// Reset: synchronous; busy stays high while the generation store clears.
module generational_handle_allocator #(
    parameter int SLOT_CAPACITY = gha_pkg::DEFAULT_SLOT_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command transfer: taken when start is high and busy is low
    input  logic                      start,
    input  gha_pkg::t_req             i_req,
    output logic                      busy,
    // result transfer: one cycle, marked by the strobe
    output logic                      o_result_valid,
    output gha_pkg::t_rsp             o_rsp,
    // max_slots register write
    input  logic                      i_cfg_we,
    input  logic [gha_pkg::CFG_W-1:0] i_cfg_wdata
);

    gha_pkg::t_ctl ctl;
    gha_pkg::t_sts sts;

    // Controller: clear pass after reset, then accept, decode and wait for memory reads
    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // Datapath: holds the request, counters, both memories and the result register
    gha_datapath #(
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_result_valid)
    );

endmodule

### tb/gha_checker.sv
`timescale 1ns / 1ps
// Checker for the generational handle allocator: watches the command, result and register ports.
// Keeps a mirror of slot generations and the freed-index FIFO to predict each result.
// Depends on gha_pkg.
module gha_checker #(
    parameter int SLOT_CAPACITY = gha_pkg::DEFAULT_SLOT_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  gha_pkg::t_req             i_req,
    input  logic                      i_result_valid,
    input  gha_pkg::t_rsp             i_rsp,
    input  logic                      i_cfg_we,
    input  logic [gha_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_pending,
    output int                        o_fail_count
);
    import gha_pkg::*;

    logic [GEN_W-1:0] gen_mirror [SLOT_CAPACITY];
    int unsigned      freed_slots [SLOT_CAPACITY];
    int unsigned      freed_head;
    int unsigned      freed_count;
    int unsigned      fresh_issued;
    logic [CFG_W-1:0] max_slots_reg;
    t_rsp             awaited_rsp [$];
    int               mismatches;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        mismatches   = 0;
    end

    // Advance the mirror by one command and return the handle or status it must produce.
    task automatic apply_command(input t_req req, output t_rsp rsp);
        int unsigned lim;
        int unsigned idx;
        int unsigned slot;
        lim = (max_slots_reg > SLOT_CAPACITY) ? SLOT_CAPACITY : 32'(max_slots_reg);
        idx = 32'(req.handle_index);
        rsp = '0;
        rsp.status = ST_FULL;
        case (req.command)
            CMD_CREATE: begin
                if (freed_count > 0) begin
                    slot        = freed_slots[freed_head] % SLOT_CAPACITY;
                    freed_head  = (freed_head + 1) % SLOT_CAPACITY;
                    freed_count = freed_count - 1;
                    rsp.result_index      = INDEX_W'(slot);
                    rsp.result_generation = gen_mirror[slot];
                    rsp.status            = ST_OK;
                end else if (fresh_issued < lim) begin
                    gen_mirror[fresh_issued] = '0;
                    rsp.result_index      = INDEX_W'(fresh_issued);
                    rsp.result_generation = '0;
                    rsp.status            = ST_OK;
                    fresh_issued = fresh_issued + 1;
                end else begin
                    rsp.result_index      = INVALID_INDEX;
                    rsp.result_generation = INVALID_GEN;
                    rsp.status            = ST_FULL;
                end
            end
            CMD_DESTROY: begin
                if (idx >= lim) begin
                    rsp.status = ST_MISS;
                end else if (freed_count >= SLOT_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    gen_mirror[idx] = gen_mirror[idx] + 1'b1;
                    freed_slots[(freed_head + freed_count) % SLOT_CAPACITY] = idx;
                    freed_count = freed_count + 1;
                    rsp.status = ST_OK;
                end
            end
            CMD_CHECK: begin
                if (idx >= lim)
                    rsp.status = ST_MISS;
                else
                    rsp.status = (gen_mirror[idx] == req.handle_generation) ? ST_OK : ST_MISS;
            end
            default: rsp.status = ST_FULL;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_rsp predicted;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_CAPACITY; k++) gen_mirror[k] = '0;
            freed_head    = 0;
            freed_count   = 0;
            fresh_issued  = 0;
            max_slots_reg = MAX_SLOTS_RESET;
            awaited_rsp.delete();
        end else begin
            // A result can never belong to a command taken at this same edge: compare first.
            if (i_result_valid) begin
                if (awaited_rsp.size() == 0) begin
                    $error("result with no command waiting: index %0h gen %0h status %0d",
                           i_rsp.result_index, i_rsp.result_generation, i_rsp.status);
                    mismatches++;
                end else begin
                    predicted = awaited_rsp.pop_front();
                    if (i_rsp.result_index !== predicted.result_index) begin
                        $error("result_index expected %0h actual %0h",
                               predicted.result_index, i_rsp.result_index);
                        mismatches++;
                    end
                    if (i_rsp.result_generation !== predicted.result_generation) begin
                        $error("result_generation expected %0h actual %0h",
                               predicted.result_generation, i_rsp.result_generation);
                        mismatches++;
                    end
                    if (i_rsp.status !== predicted.status) begin
                        $error("status expected %0d actual %0d",
                               predicted.status, i_rsp.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) max_slots_reg = i_cfg_wdata;
            if (i_start && !i_busy) begin
                apply_command(i_req, predicted);
                awaited_rsp.push_back(predicted);
            end
        end
        o_pending    <= awaited_rsp.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the generational handle allocator testbench: clock, reset, stimulus and verdict.
// Depends on gha_pkg, generational_handle_allocator and gha_checker.
module tb;
    import gha_pkg::*;

    localparam int         SLOT_CAPACITY = DEFAULT_SLOT_CAPACITY;
    // The command encoding leaves one code unused; the block must answer it with status full.
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // Longest legal quiet stretch is the store clear after reset.
    localparam int         IDLE_LIMIT    = 8 * SLOT_CAPACITY;
    localparam int         PHASE_ITEMS   = 105;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             start        = 1'b0;
    t_req             req          = '0;
    logic             busy;
    logic             result_valid;
    t_rsp             rsp;
    logic             cfg_we       = 1'b0;
    logic [CFG_W-1:0] cfg_wdata    = MAX_SLOTS_RESET;

    int               pending;
    int               fail_count;
    int               idle_cycles  = 0;
    logic [CFG_W-1:0] cur_max_slots = MAX_SLOTS_RESET;
    bit               no_idle      = 1'b0;
    // Rough guess of each slot's generation, so that checks often hit
    logic [GEN_W-1:0] gen_hint [SLOT_CAPACITY];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    generational_handle_allocator #(
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .i_req          (req),
        .busy           (busy),
        .o_result_valid (result_valid),
        .o_rsp          (rsp),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    gha_checker #(
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req          (req),
        .i_result_valid (result_valid),
        .i_rsp          (rsp),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // Watchdog: end the run when neither a command nor a result transfer happens for too long.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("generational_handle_allocator verification failed");
            $finish;
        end
    end

    function automatic int unsigned active_slots();
        return (cur_max_slots > SLOT_CAPACITY) ? SLOT_CAPACITY : 32'(cur_max_slots);
    endfunction

    // Drive one command transfer after a random gap and hold it until the block takes it.
    // Keep start high across back-to-back transfers so it is never dropped and raised in one step.
    task automatic send_command(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [GEN_W-1:0] gen);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{cmd, idx, gen};
        do @(posedge clk); while (busy !== 1'b0);
        if (cmd == CMD_DESTROY && idx < active_slots())
            gen_hint[idx] = gen_hint[idx] + 1'b1;
    endtask

    // Drop start and hold until every outstanding result has come, then let the pipe go quiet.
    task automatic settle();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write max_slots only with the block idle.
    task automatic set_max_slots(input logic [CFG_W-1:0] value);
        settle();
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        cur_max_slots  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random command: mostly in-range handles with a plausible generation, some noise.
    task automatic random_command();
        int unsigned      lim;
        int unsigned      roll;
        logic [31:0]      word;
        logic [1:0]       cmd;
        logic [INDEX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        lim  = active_slots();
        roll = $urandom_range(0, 99);
        if (roll < 40)      cmd = CMD_CREATE;
        else if (roll < 70) cmd = CMD_DESTROY;
        else if (roll < 95) cmd = CMD_CHECK;
        else                cmd = CMD_UNUSED;
        roll = $urandom_range(0, 99);
        word = $urandom();
        if (lim > 0 && roll < 75)
            idx = INDEX_W'($urandom_range(0, lim - 1));
        else if (roll < 88)
            idx = INDEX_W'(lim + $urandom_range(0, 2));
        else
            idx = word[INDEX_W-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 60)      gen = gen_hint[idx % SLOT_CAPACITY];
        else if (roll < 75) gen = gen_hint[idx % SLOT_CAPACITY] + 1'b1;
        else                gen = GEN_W'($urandom_range(0, 255));
        // Now and then hold off until the block has drained completely
        if ($urandom_range(0, 49) == 0) settle();
        send_command(cmd, idx, gen);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int items);
        set_max_slots(limit);
        no_idle = ($urandom_range(0, 3) == 0);
        repeat (items) random_command();
    endtask

    // Overfill the freed-index FIFO so that destroys get refused, then pull some back out.
    task automatic overfill_free_queue();
        set_max_slots(CFG_W'(SLOT_CAPACITY));
        no_idle = ($urandom_range(0, 1) == 1);
        repeat (SLOT_CAPACITY + 4)
            send_command(CMD_DESTROY, INDEX_W'($urandom_range(0, SLOT_CAPACITY - 1)),
                         GEN_W'($urandom_range(0, 255)));
        repeat (4)
            random_command();
        repeat (16)
            send_command(CMD_CREATE, INDEX_W'($urandom()), GEN_W'($urandom_range(0, 255)));
    endtask

    initial begin
        for (int k = 0; k < SLOT_CAPACITY; k++) gen_hint[k] = '0;

        // Reset once, then wait out the generation store clear.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);

        // Directed: two slots, run them dry, reuse freed indices, probe the range edges.
        set_max_slots(9'd2);
        send_command(CMD_CREATE,  '0, '0);
        send_command(CMD_CREATE,  '1, '1);
        send_command(CMD_CREATE,  '0, '0);       // nothing left: invalid handle
        send_command(CMD_CHECK,   24'd0, 8'd0);
        send_command(CMD_CHECK,   24'd0, 8'hFF); // stale generation
        send_command(CMD_CHECK,   24'd2, 8'd0);  // just past the limit
        send_command(CMD_CHECK,   '1, '1);
        send_command(CMD_DESTROY, '1, '0);
        send_command(CMD_DESTROY, 24'd2, '0);
        send_command(CMD_DESTROY, 24'd0, '1);
        send_command(CMD_CHECK,   24'd0, 8'd1);
        send_command(CMD_UNUSED,  '1, '1);       // unused code: no effect
        send_command(CMD_CREATE,  '0, '0);       // reuse freed slot 0
        send_command(CMD_DESTROY, 24'd1, '0);
        send_command(CMD_DESTROY, 24'd1, '0);    // same slot queued twice
        send_command(CMD_CREATE,  '0, '0);
        send_command(CMD_CREATE,  '0, '0);
        send_command(CMD_CREATE,  '0, '0);
        // Register above capacity clamps to the built slot count.
        set_max_slots('1);
        send_command(CMD_CREATE,  '0, '0);
        send_command(CMD_DESTROY, 24'd2, '0);
        // Freed index above a lowered limit still comes back out.
        set_max_slots(9'd1);
        send_command(CMD_CREATE,  '0, '0);
        // Zero slots: every create refused, every index out of range.
        set_max_slots('0);
        send_command(CMD_CREATE,  '0, '0);
        send_command(CMD_DESTROY, 24'd0, '0);
        send_command(CMD_CHECK,   24'd0, 8'd1);

        // Random phases across several limits, extremes included.
        run_phase(9'd256, PHASE_ITEMS);
        run_phase(9'd1,   PHASE_ITEMS);
        run_phase(9'd17,  PHASE_ITEMS);
        run_phase(9'd0,   PHASE_ITEMS);
        run_phase('1,     PHASE_ITEMS);
        overfill_free_queue();
        run_phase(9'd3,   PHASE_ITEMS);
        run_phase(9'd128, PHASE_ITEMS);
        run_phase(9'd256, PHASE_ITEMS);
        run_phase(9'd64,  PHASE_ITEMS);
        run_phase(9'd255, PHASE_ITEMS);

        // Drain and let the last strobes land before judging.
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("generational_handle_allocator verification clean");
        end else begin
            $display("generational_handle_allocator verification failed");
        end
        $finish;
    end

endmodule
